FILE: design/kdlp_pkg.sv
// Shared types and constants for the key debounce and long-press block.
package kdlp_pkg;

	localparam int KEY_NUM   = 4;
	localparam int KEY_ID_W  = 3;
	localparam int CNT_W     = 8;
	localparam int PHASE_W   = 2;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_LONG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD  = 1'd1;

	localparam logic [CNT_W-1:0] LONG_THRESHOLD_RST = 8'd97;
	localparam logic [CNT_W-1:0] REPEAT_PERIOD_RST  = 8'd20;

	localparam logic [KEY_ID_W-1:0] KEY_NONE  = 3'd0;
	localparam logic [KEY_ID_W-1:0] KEY_ONE   = 3'd1;
	localparam logic [KEY_ID_W-1:0] KEY_TWO   = 3'd2;
	localparam logic [KEY_ID_W-1:0] KEY_THREE = 3'd3;
	localparam logic [KEY_ID_W-1:0] KEY_FOUR  = 3'd4;

	// scan request between the input stage and the phase machine
	typedef struct packed {
		logic                valid;
		logic [KEY_ID_W-1:0] key;
	} kdlp_req_t;

	// pick the lowest-numbered pressed key from active-low levels
	function automatic logic [KEY_ID_W-1:0] pick_key(input logic [KEY_NUM-1:0] lvl_n);
		logic [KEY_ID_W-1:0] k;
		begin
			if (!lvl_n[0]) k = KEY_ONE;
			else if (!lvl_n[1]) k = KEY_TWO;
			else if (!lvl_n[2]) k = KEY_THREE;
			else if (!lvl_n[3]) k = KEY_FOUR;
			else k = KEY_NONE;
			return k;
		end
	endfunction

endpackage

FILE: design/key_debounce_long_press.sv
// Key debounce top level: four active-low keys in, short, long and repeat press events out.
// Each scan tick is one request and yields exactly one result, one tick per clock cycle
// unless downstream stalls. A request passes through the input register holding the
// encoded key, then the phase machine into the result register, which advances only when
// empty or being drained; the input register loads when empty or when the result register
// advances, so stalls hold the pipeline without loss. Threshold and period must be written
// through the config port while no tick is in flight; the block does not enforce this.
module key_debounce_long_press import kdlp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [0] key_one_n, [1] key_two_n, [2] key_three_n, [3] key_four_n, [7:4] zero
	input  logic [7:0]           s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [1:0] event_kind, [4:2] key_id, [7:5] zero
	output logic [7:0]           m_tdata
);

	kdlp_req_t           req;
	logic                advance;
	logic [KIND_W-1:0]   event_kind;
	logic [KEY_ID_W-1:0] key_id;

	kdlp_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.key_lvl_n (s_tdata[KEY_NUM-1:0]),
		.advance   (advance),
		.req       (req)
	);

	kdlp_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req        (req),
		.advance    (advance),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.event_kind (event_kind),
		.key_id     (key_id)
	);

	assign m_tdata = {3'b000, key_id, event_kind};

endmodule

FILE: design/kdlp_in_stage.sv
// Input register stage: encodes the key levels and holds the scan request.
module kdlp_in_stage import kdlp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [KEY_NUM-1:0]  key_lvl_n,
	input  logic                advance,
	output kdlp_req_t           req
);

	logic                valid_s1;
	logic [KEY_ID_W-1:0] key_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			key_s1 <= pick_key(key_lvl_n);
		end
	end

	assign req.valid = valid_s1;
	assign req.key   = key_s1;

endmodule

FILE: design/kdlp_fsm.sv
// Phase machine with hold and repeat counters, config registers and result register.
module kdlp_fsm import kdlp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	input  kdlp_req_t            req,
	output logic                 advance,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [KIND_W-1:0]    event_kind,
	output logic [KEY_ID_W-1:0]  key_id
);

	localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
	localparam logic [PHASE_W-1:0] PH_CONFIRM = 2'd1;
	localparam logic [PHASE_W-1:0] PH_HELD    = 2'd2;
	localparam logic [PHASE_W-1:0] PH_LONG    = 2'd3;

	localparam logic [KIND_W-1:0] EV_NONE   = 2'd0;
	localparam logic [KIND_W-1:0] EV_SHORT  = 2'd1;
	localparam logic [KIND_W-1:0] EV_LONG   = 2'd2;
	localparam logic [KIND_W-1:0] EV_REPEAT = 2'd3;

	logic [CNT_W-1:0]    long_threshold_q;
	logic [CNT_W-1:0]    repeat_period_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [KEY_ID_W-1:0] held_key_q;
	logic [CNT_W-1:0]    hold_count_q;
	logic [CNT_W-1:0]    repeat_count_q;
	logic                out_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [KEY_ID_W-1:0] id_q;

	logic [PHASE_W-1:0]  phase_d;
	logic [KEY_ID_W-1:0] held_key_d;
	logic [CNT_W-1:0]    hold_count_d;
	logic [CNT_W-1:0]    repeat_count_d;
	logic [CNT_W-1:0]    hold_inc;
	logic [CNT_W-1:0]    repeat_inc;
	logic [KIND_W-1:0]   kind_d;
	logic [KEY_ID_W-1:0] id_d;
	logic                same;
	logic                step;

	assign advance = !out_valid_q || out_ready;
	assign step    = advance && req.valid;
	assign same    = (req.key == held_key_q);
	assign hold_inc   = hold_count_q + 1'b1;
	assign repeat_inc = repeat_count_q + 1'b1;

	always_comb begin
		phase_d        = phase_q;
		held_key_d     = held_key_q;
		hold_count_d   = hold_count_q;
		repeat_count_d = repeat_count_q;
		kind_d         = EV_NONE;
		id_d           = KEY_NONE;
		case (phase_q)
			PH_IDLE: begin
				if (req.key != KEY_NONE) begin
					held_key_d = req.key;
					phase_d    = PH_CONFIRM;
				end
			end
			PH_CONFIRM: begin
				phase_d = same ? PH_HELD : PH_IDLE;
			end
			PH_HELD: begin
				if (same) begin
					hold_count_d = hold_inc;
					if (hold_inc > long_threshold_q) begin
						hold_count_d = '0;
						phase_d      = PH_LONG;
						kind_d       = EV_LONG;
						id_d         = held_key_q;
					end
				end else begin
					hold_count_d = '0;
					phase_d      = PH_IDLE;
					kind_d       = EV_SHORT;
					id_d         = held_key_q;
				end
			end
			PH_LONG: begin
				if (same) begin
					repeat_count_d = repeat_inc;
					if (repeat_inc == repeat_period_q) begin
						repeat_count_d = '0;
						kind_d         = EV_REPEAT;
						id_d           = held_key_q;
					end
				end else begin
					repeat_count_d = '0;
					phase_d        = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_threshold_q <= LONG_THRESHOLD_RST;
			repeat_period_q  <= REPEAT_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LONG_THRESHOLD: long_threshold_q <= cfg_data;
				CFG_REPEAT_PERIOD:  repeat_period_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			held_key_q     <= KEY_NONE;
			hold_count_q   <= '0;
			repeat_count_q <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			held_key_q     <= held_key_d;
			hold_count_q   <= hold_count_d;
			repeat_count_q <= repeat_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			kind_q <= kind_d;
			id_q   <= id_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = kind_q;
	assign key_id     = id_q;

	a_id_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((kind_q == EV_NONE) == (id_q == KEY_NONE)))
		else $error("key id and event kind disagree");

	a_long_from_held: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LONG && $past(phase_q) != PH_LONG) |-> $past(phase_q) == PH_HELD)
		else $error("long-held phase entered from outside held");

	a_hold_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HELD) |-> (hold_count_q == '0))
		else $error("hold count nonzero outside held phase");

	a_repeat_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_LONG) |-> (repeat_count_q == '0))
		else $error("repeat count nonzero outside long-held phase");

	a_long_event_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(step && kind_d == EV_LONG) |=> (phase_q == PH_LONG && kind_q == EV_LONG))
		else $error("long event without long-held phase");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the key debounce block with short, long and repeat press events.
module testbench;
	import kdlp_pkg::*;

	typedef enum logic [KIND_W-1:0] {EV_NONE, EV_SHORT, EV_LONG, EV_REPEAT} press_kind_t;
	typedef enum logic [PHASE_W-1:0] {PH_IDLE, PH_CONFIRM, PH_HELD, PH_LONG} scan_phase_t;

	typedef struct packed {
		logic [KEY_ID_W-1:0] key;
		press_kind_t         kind;
	} press_event_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_LONG_THRESHOLD;
	logic [CNT_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// [0] key_one_n, [1] key_two_n, [2] key_three_n, [3] key_four_n, [7:4] zero
	logic [7:0]           s_tdata = 8'hFF;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// [1:0] event_kind, [4:2] key_id, [7:5] zero
	logic [7:0]           m_tdata;

	logic [KEY_NUM-1:0] pending_ticks[$];
	press_event_t       expected_events[$];

	scan_phase_t         scan_phase;
	logic [KEY_ID_W-1:0] tracked_key;
	logic [CNT_W-1:0]    held_ticks;
	logic [CNT_W-1:0]    repeat_ticks;
	logic [CNT_W-1:0]    long_thr;
	logic [CNT_W-1:0]    repeat_per;

	logic [CNT_W-1:0] gen_thr = LONG_THRESHOLD_RST;
	logic [CNT_W-1:0] gen_per = REPEAT_PERIOD_RST;
	logic             no_idle = 1'b0;
	int               holdoff_asked = 0;
	int               holdoff_taken = 0;
	int               stall_left = 0;
	int               mismatch_count = 0;
	int               tick_count = 0;
	int               cfg_writes = 0;
	int               short_count = 0;
	int               long_count = 0;
	int               repeat_count = 0;

	key_debounce_long_press dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		begin
			mismatch_count++;
			$display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
		end
	endtask

	task automatic advance_keys(input logic [KEY_NUM-1:0] lvl_n, output press_event_t res);
		logic [KEY_ID_W-1:0] seen;
		begin
			seen = KEY_NONE;
			for (int i = KEY_NUM - 1; i >= 0; i--)
				if (!lvl_n[i])
					seen = KEY_ID_W'(i + 1);
			res.kind = EV_NONE;
			res.key = KEY_NONE;
			case (scan_phase)
			PH_IDLE: begin
				if (seen != KEY_NONE) begin
					tracked_key = seen;
					scan_phase = PH_CONFIRM;
				end
			end
			PH_CONFIRM: begin
				scan_phase = (seen == tracked_key) ? PH_HELD : PH_IDLE;
			end
			PH_HELD: begin
				if (seen == tracked_key) begin
					held_ticks = held_ticks + 1'b1;
					if (held_ticks > long_thr) begin
						held_ticks = '0;
						scan_phase = PH_LONG;
						res.kind = EV_LONG;
						res.key = tracked_key;
					end
				end else begin
					held_ticks = '0;
					scan_phase = PH_IDLE;
					res.kind = EV_SHORT;
					res.key = tracked_key;
				end
			end
			default: begin
				if (seen == tracked_key) begin
					repeat_ticks = repeat_ticks + 1'b1;
					if (repeat_ticks == repeat_per) begin
						repeat_ticks = '0;
						res.kind = EV_REPEAT;
						res.key = tracked_key;
					end
				end else begin
					repeat_ticks = '0;
					scan_phase = PH_IDLE;
				end
			end
			endcase
		end
	endtask

	// driver: present the next pending tick once the previous request is taken
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (pending_ticks.size() != 0 && (no_idle || $urandom_range(0, 99) >= 36)) begin
				s_tdata <= {4'b0000, pending_ticks.pop_front()};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus long hold-offs on request
	always @(posedge clk) begin
		if (holdoff_taken != holdoff_asked) begin
			holdoff_taken <= holdoff_asked;
			stall_left <= 80;
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(0, 99) >= 36);
		end
	end

	// monitor: predict on accepted ticks, check accepted events
	always @(posedge clk) begin
		press_event_t res;
		press_event_t want;
		if (!arst_n) begin
			scan_phase = PH_IDLE;
			tracked_key = KEY_NONE;
			held_ticks = '0;
			repeat_ticks = '0;
			long_thr = LONG_THRESHOLD_RST;
			repeat_per = REPEAT_PERIOD_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				CFG_LONG_THRESHOLD: long_thr = cfg_data;
				CFG_REPEAT_PERIOD:  repeat_per = cfg_data;
				default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				advance_keys(s_tdata[KEY_NUM-1:0], res);
				expected_events.push_back(res);
				tick_count++;
				case (res.kind)
				EV_SHORT:  short_count++;
				EV_LONG:   long_count++;
				EV_REPEAT: repeat_count++;
				default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_events.size() == 0) begin
					flag_mismatch("unexpected event", m_tdata, 0);
				end else begin
					want = expected_events.pop_front();
					if (m_tdata[1:0] !== want.kind)
						flag_mismatch("event kind", m_tdata[1:0], want.kind);
					if (m_tdata[4:2] !== want.key)
						flag_mismatch("key id", m_tdata[4:2], want.key);
				end
			end
		end
	end

	task automatic add_ticks(input logic [KEY_NUM-1:0] lvl_n, input int n);
		begin
			repeat (n) pending_ticks.push_back(lvl_n);
		end
	endtask

	task automatic settle();
		begin
			@(negedge clk);
			while (pending_ticks.size() != 0 || s_tvalid || expected_events.size() != 0)
				@(negedge clk);
			repeat (4) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
		begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= value;
			@(posedge clk);
			cfg_we <= 1'b0;
			if (idx == CFG_LONG_THRESHOLD)
				gen_thr = value;
			else
				gen_per = value;
			cfg_writes++;
		end
	endtask

	task automatic random_phase(input int n);
		int pushed;
		int pick;
		int k;
		int len;
		logic [KEY_NUM-1:0] lvl;
		begin
			pushed = 0;
			while (pushed < n) begin
				pick = $urandom_range(0, 99);
				if (pick < 75) begin
					k = $urandom_range(1, KEY_NUM);
					len = $urandom_range(1, gen_thr + 4 * gen_per + 4);
					for (int j = 0; j < len; j++) begin
						lvl = KEY_NUM'($urandom_range(0, 15));
						lvl = lvl | KEY_NUM'((1 << (k - 1)) - 1);
						lvl[k-1] = 1'b0;
						pending_ticks.push_back(lvl);
					end
					pushed += len;
					len = $urandom_range(0, 3);
					add_ticks(4'hF, len);
					pushed += len;
				end else begin
					len = $urandom_range(1, 6);
					repeat (len) pending_ticks.push_back(KEY_NUM'($urandom_range(0, 15)));
					pushed += len;
				end
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		add_ticks(4'hF, 2);
		add_ticks(4'h0, 3);
		add_ticks(4'hF, 1);
		add_ticks(4'b1101, 3);
		add_ticks(4'b1011, 1);
		add_ticks(4'b0111, 1);
		add_ticks(4'b1011, 1);
		add_ticks(4'b0101, 2);
		add_ticks(4'hF, 1);
		settle();

		write_reg(CFG_LONG_THRESHOLD, 8'd1);
		write_reg(CFG_REPEAT_PERIOD, 8'd1);
		add_ticks(4'b0111, 7);
		add_ticks(4'b1110, 1);
		add_ticks(4'hF, 1);
		settle();

		// hold past the top threshold with no idling on either side
		write_reg(CFG_LONG_THRESHOLD, 8'd255);
		write_reg(CFG_REPEAT_PERIOD, 8'd255);
		no_idle = 1'b1;
		add_ticks(4'b1101, 300);
		add_ticks(4'hF, 2);
		settle();
		no_idle = 1'b0;

		// lower the period under the running count, then hold through the wrap
		write_reg(CFG_LONG_THRESHOLD, 8'd1);
		write_reg(CFG_REPEAT_PERIOD, 8'd255);
		add_ticks(4'b1011, 12);
		settle();
		write_reg(CFG_REPEAT_PERIOD, 8'd3);
		add_ticks(4'b1011, 260);
		add_ticks(4'hF, 2);
		holdoff_asked++;
		settle();

		for (int p = 0; p < 6; p++) begin
			if (p == 0) begin
				write_reg(CFG_LONG_THRESHOLD, 8'd1);
				write_reg(CFG_REPEAT_PERIOD, 8'd1);
			end else begin
				write_reg(CFG_LONG_THRESHOLD, CNT_W'($urandom_range(1, 16)));
				write_reg(CFG_REPEAT_PERIOD, CNT_W'($urandom_range(1, 8)));
			end
			random_phase(110);
			if (p == 2)
				holdoff_asked++;
			settle();
		end

		repeat (8) @(negedge clk);
		if (expected_events.size() != 0)
			flag_mismatch("events left over", 0, expected_events.size());
		$display("covered %0d scan ticks over %0d register writes, thresholds and periods 1..255",
			tick_count, cfg_writes);
		$display("events seen: %0d short, %0d long, %0d repeat; %0d mismatches",
			short_count, long_count, repeat_count, mismatch_count);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout with %0d events outstanding", expected_events.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
design/kdlp_pkg.sv
design/kdlp_in_stage.sv
design/kdlp_fsm.sv
design/key_debounce_long_press.sv
tb/testbench.sv
